### sv/pproj_pkg.sv
// ----------------------------------------------------------------------------
// pproj_pkg
// Shared types and constants for the lens-distorting pinhole projector.
// ----------------------------------------------------------------------------
package pproj_pkg;

  // Restoring divider: one quotient bit per stage, bits 30 down to 0
  localparam int unsigned DIV_STAGES = 31;

  // Magnitude limit of the normalized coordinate, 2.0 in Q.28
  localparam logic [30:0] XD_LIM = 31'd536870912;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_DEPTH = 2'd1;
  localparam logic [1:0] ST_SAT   = 2'd2;

  // Register indexes
  typedef enum logic [2:0] {
    REG_FOCAL_X  = 3'd0,
    REG_FOCAL_Y  = 3'd1,
    REG_CENTER_X = 3'd2,
    REG_CENTER_Y = 3'd3,
    REG_K1       = 3'd4,
    REG_K2       = 3'd5,
    REG_P1       = 3'd6,
    REG_P2       = 3'd7
  } reg_idx_e;

  // Reset values
  localparam logic [30:0]        RST_FOCAL_X  = 31'd65536;
  localparam logic [30:0]        RST_FOCAL_Y  = 31'd65536;
  localparam logic signed [31:0] RST_CENTER_X = 32'sd0;
  localparam logic signed [31:0] RST_CENTER_Y = 32'sd0;
  localparam logic signed [31:0] RST_K1       = 32'sd23401472;
  localparam logic signed [31:0] RST_K2       = -32'sd9855957;
  localparam logic signed [31:0] RST_P1       = -32'sd409296;
  localparam logic signed [31:0] RST_P2       = 32'sd76362;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } point_t;

  typedef struct packed {
    logic signed [31:0] pixel_u;
    logic signed [31:0] pixel_v;
    logic [1:0]         status;
  } pixel_t;

  typedef struct packed {
    logic [30:0]        focal_x;
    logic [30:0]        focal_y;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] radial_k1;
    logic signed [31:0] radial_k2;
    logic signed [31:0] tangential_p1;
    logic signed [31:0] tangential_p2;
  } cfg_t;

  // One divider lane: |P| << 28 divided by Z
  typedef struct packed {
    logic        neg;
    logic        ovf;
    logic [30:0] d;
    logic [2:0]  lo;
    logic [31:0] rem;
    logic [30:0] q;
  } div_lane_t;

  typedef struct packed {
    logic      valid;
    logic      bad;
    div_lane_t x;
    div_lane_t y;
  } div_stage_t;

endpackage

### sv/pinhole_project_with_lens_distortion_top.sv
// ----------------------------------------------------------------------------
// pinhole_project_with_lens_distortion_top
// Pinhole projection of a camera-frame point with radial/tangential distortion.
// ----------------------------------------------------------------------------
// Pipeline: 1 entry stage, 31 divider stages and 10 distortion stages from
//   input transaction to result; a downstream stall holds every stage.
// Throughput: one transaction per unstalled clock, set by bit-per-stage divide.
// Reset: rst_ni clears all pipeline valid bits and loads the default
//   intrinsics and distortion coefficients.
// ----------------------------------------------------------------------------
module pinhole_project_with_lens_distortion_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  // point channel
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  pproj_pkg::point_t in_data_i,
  // pixel channel
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output pproj_pkg::pixel_t out_data_o,
  // configuration write port
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_idx_i,
  input  logic [31:0]       cfg_data_i
);

  pproj_pkg::cfg_t       cfg_q;
  pproj_pkg::div_stage_t div_out;
  logic                  en;

  // Whole pipeline moves together; it holds only while a finished
  // transaction sits at the output and the consumer stalls.
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.focal_x       <= pproj_pkg::RST_FOCAL_X;
      cfg_q.focal_y       <= pproj_pkg::RST_FOCAL_Y;
      cfg_q.center_x      <= pproj_pkg::RST_CENTER_X;
      cfg_q.center_y      <= pproj_pkg::RST_CENTER_Y;
      cfg_q.radial_k1     <= pproj_pkg::RST_K1;
      cfg_q.radial_k2     <= pproj_pkg::RST_K2;
      cfg_q.tangential_p1 <= pproj_pkg::RST_P1;
      cfg_q.tangential_p2 <= pproj_pkg::RST_P2;
    end else if (cfg_we_i) begin
      unique case (pproj_pkg::reg_idx_e'(cfg_idx_i))
        pproj_pkg::REG_FOCAL_X:  cfg_q.focal_x       <= cfg_data_i[30:0];
        pproj_pkg::REG_FOCAL_Y:  cfg_q.focal_y       <= cfg_data_i[30:0];
        pproj_pkg::REG_CENTER_X: cfg_q.center_x      <= cfg_data_i;
        pproj_pkg::REG_CENTER_Y: cfg_q.center_y      <= cfg_data_i;
        pproj_pkg::REG_K1:       cfg_q.radial_k1     <= cfg_data_i;
        pproj_pkg::REG_K2:       cfg_q.radial_k2     <= cfg_data_i;
        pproj_pkg::REG_P1:       cfg_q.tangential_p1 <= cfg_data_i;
        pproj_pkg::REG_P2:       cfg_q.tangential_p2 <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Depth divide: (P << 28) / Z for X and Y
  pproj_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .div_o      (div_out)
  );

  // Distortion, intrinsics, saturation; last stage is the output register
  pproj_dist u_dist (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .div_i       (div_out),
    .cfg_i       (cfg_q),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

`ifndef SYNTH
  a_depth_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == pproj_pkg::ST_DEPTH
      |-> out_data_o.pixel_u == 32'sd0 && out_data_o.pixel_v == 32'sd0)
    else $error("depth fault transaction with nonzero pixel");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.status == pproj_pkg::ST_OK
      || out_data_o.status == pproj_pkg::ST_DEPTH
      || out_data_o.status == pproj_pkg::ST_SAT)
    else $error("undefined status code");

  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("input taken while pipeline is frozen");
`endif

endmodule

### sv/pproj_div.sv
// ----------------------------------------------------------------------------
// pproj_div
// Pipelined restoring divider, two lanes (X/Z and Y/Z), one bit per stage.
// ----------------------------------------------------------------------------
module pproj_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  in_valid_i,
  input  pproj_pkg::point_t     in_data_i,
  output pproj_pkg::div_stage_t div_o
);

  pproj_pkg::div_stage_t st_q [pproj_pkg::DIV_STAGES+1];
  pproj_pkg::div_stage_t st_d [pproj_pkg::DIV_STAGES+1];

  function automatic pproj_pkg::div_lane_t init_lane(logic signed [31:0] p,
                                                     logic signed [31:0] z);
    pproj_pkg::div_lane_t l;
    logic [31:0] mag;
    mag   = p[31] ? 32'(-p) : 32'(p);
    l     = '0;
    l.neg = p[31];
    l.d   = z[30:0];
    l.lo  = mag[2:0];
    // numerator bits 59..31 are mag[31:3]
    l.ovf = {3'b000, mag[31:3]} >= {1'b0, z[30:0]};
    l.rem = l.ovf ? '0 : {3'b000, mag[31:3]};
    return l;
  endfunction

  function automatic pproj_pkg::div_lane_t step_lane(pproj_pkg::div_lane_t l,
                                                     logic [4:0] pos);
    pproj_pkg::div_lane_t r;
    logic        nb;
    logic [31:0] sh;
    r  = l;
    nb = (pos >= 5'd28) ? l.lo[2'(pos - 5'd28)] : 1'b0;
    sh = {l.rem[30:0], nb};
    if (sh >= {1'b0, l.d}) begin
      r.rem      = sh - {1'b0, l.d};
      r.q[pos]   = 1'b1;
    end else begin
      r.rem      = sh;
    end
    return r;
  endfunction

  always_comb begin
    st_d[0].valid = in_valid_i;
    st_d[0].bad   = (in_data_i.point_z <= 32'sd0);
    st_d[0].x     = init_lane(in_data_i.point_x, in_data_i.point_z);
    st_d[0].y     = init_lane(in_data_i.point_y, in_data_i.point_z);
    for (int k = 1; k <= pproj_pkg::DIV_STAGES; k++) begin
      st_d[k].valid = st_q[k-1].valid;
      st_d[k].bad   = st_q[k-1].bad;
      st_d[k].x     = step_lane(st_q[k-1].x, 5'(pproj_pkg::DIV_STAGES - k));
      st_d[k].y     = step_lane(st_q[k-1].y, 5'(pproj_pkg::DIV_STAGES - k));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= pproj_pkg::DIV_STAGES; k++) st_q[k] <= '0;
    end else if (en_i) begin
      for (int k = 0; k <= pproj_pkg::DIV_STAGES; k++) st_q[k] <= st_d[k];
    end
  end

  assign div_o = st_q[pproj_pkg::DIV_STAGES];

endmodule

### sv/pproj_dist.sv
// ----------------------------------------------------------------------------
// pproj_dist
// Ten-stage distortion and intrinsics pipeline after the depth divide.
// ----------------------------------------------------------------------------
module pproj_dist (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  pproj_pkg::div_stage_t div_i,
  input  pproj_pkg::cfg_t       cfg_i,
  output logic                  out_valid_o,
  output pproj_pkg::pixel_t     out_data_o
);

  localparam int unsigned NST = 10;

  localparam logic signed [39:0] D_ONE    = 40'sd268435456;
  localparam logic signed [39:0] D_MAX    = 40'sd8589934591;
  localparam logic signed [39:0] D_MIN    = -40'sd8589934592;
  localparam logic signed [39:0] DIST_MAX = 40'sd4294967295;
  localparam logic signed [39:0] DIST_MIN = -40'sd4294967296;
  localparam logic signed [37:0] PIX_MAX  = 38'sd2147483647;
  localparam logic signed [37:0] PIX_MIN  = -38'sd2147483648;

  typedef struct packed {
    logic               valid;
    logic               bad;
    logic               sat;
    logic signed [30:0] xd;
    logic signed [30:0] yd;
    logic [30:0]        xx;
    logic [30:0]        yy;
    logic signed [31:0] xy;
    logic [31:0]        r2;
    logic [31:0]        tx;
    logic [31:0]        ty;
    logic [30:0]        r4;
    logic signed [35:0] k1t;
    logic signed [37:0] k2t;
    logic signed [35:0] p1xy;
    logic signed [35:0] p2xy;
    logic signed [36:0] p2tx;
    logic signed [36:0] p1ty;
    logic signed [33:0] dd;
    logic signed [35:0] xrad;
    logic signed [35:0] yrad;
    logic signed [32:0] xdist;
    logic signed [32:0] ydist;
    logic signed [37:0] u;
    logic signed [37:0] v;
    logic [31:0]        pu;
    logic [31:0]        pv;
    logic [1:0]         status;
  } dist_t;

  dist_t s_q [1:NST];
  dist_t s_d [1:NST];

  // stage 1: clamp quotient, apply sign
  always_comb begin
    logic [30:0] mx, my;
    s_d[1]       = '0;
    s_d[1].valid = div_i.valid;
    s_d[1].bad   = div_i.bad;
    mx = div_i.x.q;
    my = div_i.y.q;
    if (div_i.x.ovf || div_i.x.q > pproj_pkg::XD_LIM) begin
      mx = pproj_pkg::XD_LIM;
      s_d[1].sat = 1'b1;
    end
    if (div_i.y.ovf || div_i.y.q > pproj_pkg::XD_LIM) begin
      my = pproj_pkg::XD_LIM;
      s_d[1].sat = 1'b1;
    end
    s_d[1].xd = div_i.x.neg ? $signed(-mx) : $signed(mx);
    s_d[1].yd = div_i.y.neg ? $signed(-my) : $signed(my);
  end

  // stage 2: squares and cross term
  always_comb begin
    logic signed [63:0] pxx, pyy, pxy;
    s_d[2] = s_q[1];
    pxx = s_q[1].xd * s_q[1].xd;
    pyy = s_q[1].yd * s_q[1].yd;
    pxy = s_q[1].xd * s_q[1].yd;
    s_d[2].xx = pxx[58:28];
    s_d[2].yy = pyy[58:28];
    s_d[2].xy = pxy[59:28];
  end

  // stage 3: r^2, tangential arguments, cross-term products
  always_comb begin
    logic [31:0]        r2;
    logic [32:0]        sx, sy;
    logic signed [63:0] a, b;
    s_d[3] = s_q[2];
    r2 = {1'b0, s_q[2].xx} + {1'b0, s_q[2].yy};
    sx = {1'b0, r2} + {1'b0, s_q[2].xx, 1'b0};
    sy = {1'b0, r2} + {1'b0, s_q[2].yy, 1'b0};
    s_d[3].r2 = r2;
    s_d[3].tx = sx[32:1];
    s_d[3].ty = sy[32:1];
    a = cfg_i.tangential_p1 * s_q[2].xy;
    b = cfg_i.tangential_p2 * s_q[2].xy;
    s_d[3].p1xy = a[62:27];
    s_d[3].p2xy = b[62:27];
  end

  // stage 4: r^4, k1 term, tangential square terms
  always_comb begin
    logic [63:0]        pr;
    logic signed [63:0] a, b, c;
    s_d[4] = s_q[3];
    pr = {32'd0, s_q[3].r2} * {32'd0, s_q[3].r2};
    s_d[4].r4 = pr[62:32];
    a = cfg_i.radial_k1 * $signed({1'b0, s_q[3].r2});
    b = cfg_i.tangential_p2 * $signed({1'b0, s_q[3].tx});
    c = cfg_i.tangential_p1 * $signed({1'b0, s_q[3].ty});
    s_d[4].k1t  = a[63:28];
    s_d[4].p2tx = b[63:27];
    s_d[4].p1ty = c[63:27];
  end

  // stage 5: k2 term
  always_comb begin
    logic signed [63:0] a;
    s_d[5] = s_q[4];
    a = cfg_i.radial_k2 * $signed({1'b0, s_q[4].r4});
    s_d[5].k2t = a[61:24];
  end

  // stage 6: radial factor with clamp
  always_comb begin
    logic signed [39:0] sum;
    s_d[6] = s_q[5];
    sum = D_ONE + {{4{s_q[5].k1t[35]}}, s_q[5].k1t} + {{2{s_q[5].k2t[37]}}, s_q[5].k2t};
    if (sum > D_MAX) begin
      sum = D_MAX;
      s_d[6].sat = 1'b1;
    end else if (sum < D_MIN) begin
      sum = D_MIN;
      s_d[6].sat = 1'b1;
    end
    s_d[6].dd = sum[33:0];
  end

  // stage 7: radial part
  always_comb begin
    logic signed [63:0] a, b;
    s_d[7] = s_q[6];
    a = s_q[6].xd * s_q[6].dd;
    b = s_q[6].yd * s_q[6].dd;
    s_d[7].xrad = a[63:28];
    s_d[7].yrad = b[63:28];
  end

  // stage 8: distorted coordinate with clamp
  always_comb begin
    logic signed [39:0] sx, sy;
    s_d[8] = s_q[7];
    sx = {{4{s_q[7].xrad[35]}}, s_q[7].xrad} + {{4{s_q[7].p1xy[35]}}, s_q[7].p1xy}
       + {{3{s_q[7].p2tx[36]}}, s_q[7].p2tx};
    sy = {{4{s_q[7].yrad[35]}}, s_q[7].yrad} + {{3{s_q[7].p1ty[36]}}, s_q[7].p1ty}
       + {{4{s_q[7].p2xy[35]}}, s_q[7].p2xy};
    if (sx > DIST_MAX) begin
      sx = DIST_MAX;
      s_d[8].sat = 1'b1;
    end else if (sx < DIST_MIN) begin
      sx = DIST_MIN;
      s_d[8].sat = 1'b1;
    end
    if (sy > DIST_MAX) begin
      sy = DIST_MAX;
      s_d[8].sat = 1'b1;
    end else if (sy < DIST_MIN) begin
      sy = DIST_MIN;
      s_d[8].sat = 1'b1;
    end
    s_d[8].xdist = sx[32:0];
    s_d[8].ydist = sy[32:0];
  end

  // stage 9: focal scaling
  always_comb begin
    logic signed [65:0] a, b;
    s_d[9] = s_q[8];
    a = $signed({1'b0, cfg_i.focal_x}) * s_q[8].xdist;
    b = $signed({1'b0, cfg_i.focal_y}) * s_q[8].ydist;
    s_d[9].u = a[65:28];
    s_d[9].v = b[65:28];
  end

  // stage 10: principal point, saturate, status
  always_comb begin
    logic signed [37:0] su, sv;
    logic               sat;
    s_d[10] = s_q[9];
    sat = s_q[9].sat;
    su  = s_q[9].u + {{6{cfg_i.center_x[31]}}, cfg_i.center_x};
    sv  = s_q[9].v + {{6{cfg_i.center_y[31]}}, cfg_i.center_y};
    if (su > PIX_MAX) begin
      su = PIX_MAX;
      sat = 1'b1;
    end else if (su < PIX_MIN) begin
      su = PIX_MIN;
      sat = 1'b1;
    end
    if (sv > PIX_MAX) begin
      sv = PIX_MAX;
      sat = 1'b1;
    end else if (sv < PIX_MIN) begin
      sv = PIX_MIN;
      sat = 1'b1;
    end
    if (s_q[9].bad) begin
      s_d[10].pu     = '0;
      s_d[10].pv     = '0;
      s_d[10].status = pproj_pkg::ST_DEPTH;
    end else begin
      s_d[10].pu     = su[31:0];
      s_d[10].pv     = sv[31:0];
      s_d[10].status = sat ? pproj_pkg::ST_SAT : pproj_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 1; k <= NST; k++) s_q[k] <= '0;
    end else if (en_i) begin
      for (int k = 1; k <= NST; k++) s_q[k] <= s_d[k];
    end
  end

  assign out_valid_o        = s_q[NST].valid;
  assign out_data_o.pixel_u = s_q[NST].pu;
  assign out_data_o.pixel_v = s_q[NST].pv;
  assign out_data_o.status  = s_q[NST].status;

endmodule
